// File: rtl/bst_pkg.sv
// Shared types, codes and helper functions of the BSON stream tokenizer.
package bst_pkg;

	// Limits of the accepted grammar.
	localparam int MAX_NAME_LEN = 256;
	localparam int MAX_DEPTH    = 16;

	// Widths of the result fields and of the internal state.
	localparam int EVENT_W = 4;
	localparam int TYPE_W  = 3;
	localparam int DEPTH_W = 5;
	localparam int ERR_W   = 2;
	localparam int VALUE_W = 64;
	// Byte counter: holds a positive 31-bit string length or a name length.
	localparam int CNT_W   = 31;

	// Event codes reported with each word.
	typedef enum logic [EVENT_W-1:0] {
		EV_DOCLEN   = 4'd0,
		EV_TYPE     = 4'd1,
		EV_NAME     = 4'd2,
		EV_NAME_END = 4'd3,
		EV_STRLEN   = 4'd4,
		EV_VALUE    = 4'd5,
		EV_STRBYTE  = 4'd6,
		EV_SUB_END  = 4'd7,
		EV_DOC_END  = 4'd8,
		EV_ERROR    = 4'd9
	} event_t;

	// Element type codes.
	typedef enum logic [TYPE_W-1:0] {
		T_DOUBLE = 3'd0,
		T_STRING = 3'd1,
		T_DOC    = 3'd2,
		T_ARRAY  = 3'd3,
		T_BOOL   = 3'd4,
		T_INT64  = 3'd5,
		T_NULL   = 3'd6,
		T_INT32  = 3'd7
	} elem_type_t;

	// Error codes.
	typedef enum logic [ERR_W-1:0] {
		ERR_NONE      = 2'd0,
		ERR_BAD_TYPE  = 2'd1,
		ERR_NAME_LONG = 2'd2,
		ERR_TOO_DEEP  = 2'd3
	} err_t;

	// Type bytes as they appear in the stream.
	localparam logic [7:0] BT_DOUBLE    = 8'h01;
	localparam logic [7:0] BT_STRING    = 8'h02;
	localparam logic [7:0] BT_DOC       = 8'h03;
	localparam logic [7:0] BT_ARRAY     = 8'h04;
	localparam logic [7:0] BT_BOOL      = 8'h08;
	localparam logic [7:0] BT_DATETIME  = 8'h09;
	localparam logic [7:0] BT_NULL      = 8'h0A;
	localparam logic [7:0] BT_INT32     = 8'h10;
	localparam logic [7:0] BT_TIMESTAMP = 8'h11;
	localparam logic [7:0] BT_INT64     = 8'h12;

	// Parser phase, one-hot.
	typedef enum logic [6:0] {
		PH_DOCLEN = 7'b0000001,
		PH_TYPE   = 7'b0000010,
		PH_NAME   = 7'b0000100,
		PH_VALUE  = 7'b0001000,
		PH_STRLEN = 7'b0010000,
		PH_STRING = 7'b0100000,
		PH_ERROR  = 7'b1000000
	} phase_t;

	// Parser state carried from word to word.
	typedef struct packed {
		phase_t              phase;
		elem_type_t          elem_type;
		logic [CNT_W-1:0]    cnt;
		logic [VALUE_W-1:0]  acc;
		logic [DEPTH_W-1:0]  depth;
		err_t                err;
	} state_t;

	// One result word.
	typedef struct packed {
		event_t              ev;
		elem_type_t          elem_type;
		logic [7:0]          byte_value;
		logic [VALUE_W-1:0]  value;
		logic                value_valid;
		logic [DEPTH_W-1:0]  depth;
		err_t                err;
	} result_t;

	// Type mapping result: known flag plus type code.
	typedef struct packed {
		logic       known;
		elem_type_t code;
	} type_map_t;

	// Maps a stream type byte to a type code.
	function automatic type_map_t map_type(input logic [7:0] b);
		type_map_t m;
		m.known = 1'b1;
		case (b)
			BT_DOUBLE:                             m.code = T_DOUBLE;
			BT_STRING:                             m.code = T_STRING;
			BT_DOC:                                m.code = T_DOC;
			BT_ARRAY:                              m.code = T_ARRAY;
			BT_BOOL:                               m.code = T_BOOL;
			BT_DATETIME, BT_TIMESTAMP, BT_INT64:   m.code = T_INT64;
			BT_NULL:                               m.code = T_NULL;
			BT_INT32:                              m.code = T_INT32;
			default: begin
				m.known = 1'b0;
				m.code  = T_DOUBLE;
			end
		endcase
		return m;
	endfunction

	// Index of the last value byte of a scalar type.
	function automatic logic [2:0] last_value_idx(input elem_type_t t);
		logic [2:0] idx;
		case (t)
			T_BOOL:  idx = 3'd0;
			T_INT32: idx = 3'd3;
			default: idx = 3'd7;
		endcase
		return idx;
	endfunction

endpackage

// File: rtl/bst_step.sv
// Next-state and result logic of the tokenizer for one stream byte.
module bst_step (
	input  bst_pkg::state_t  cur_state,
	input  logic [7:0]       data_byte,
	input  logic             restart,
	output bst_pkg::state_t  nxt_state,
	output bst_pkg::result_t result
);

	bst_pkg::state_t             st;
	bst_pkg::state_t             nxt;
	bst_pkg::type_map_t          tmap;
	bst_pkg::event_t             ev;
	logic [bst_pkg::VALUE_W-1:0] val;
	logic                        vvalid;
	logic [bst_pkg::VALUE_W-1:0] acc_merged;
	logic [2:0]                  lane;
	logic [bst_pkg::CNT_W-1:0]   cnt_dec;

	// Restart clears error, depth and counters before the byte is taken.
	always_comb begin
		st = cur_state;
		if (restart) begin
			st.phase = bst_pkg::PH_DOCLEN;
			st.cnt   = '0;
			st.acc   = '0;
			st.depth = '0;
			st.err   = bst_pkg::ERR_NONE;
		end
	end

	assign tmap = bst_pkg::map_type(data_byte);

	// Little-endian byte lane select; length bytes use only the low four lanes.
	always_comb begin
		if (st.phase == bst_pkg::PH_STRLEN) begin
			lane = {1'b0, st.cnt[1:0]};
		end else begin
			lane = st.cnt[2:0];
		end
		acc_merged = st.acc;
		for (int i = 0; i < 8; i++) begin
			if (lane == 3'(i)) begin
				acc_merged[8*i +: 8] = st.acc[8*i +: 8] | data_byte;
			end
		end
	end

	// String byte countdown saturates at zero.
	assign cnt_dec = (st.cnt != '0) ? st.cnt - 1'b1 : '0;

	// Phase transitions.
	always_comb begin
		nxt    = st;
		ev     = bst_pkg::EV_ERROR;
		val    = '0;
		vvalid = 1'b0;
		unique case (st.phase)
			bst_pkg::PH_DOCLEN: begin
				ev = bst_pkg::EV_DOCLEN;
				if (st.cnt >= bst_pkg::CNT_W'(3)) begin
					nxt.cnt   = '0;
					nxt.phase = bst_pkg::PH_TYPE;
				end else begin
					nxt.cnt = st.cnt + 1'b1;
				end
			end
			bst_pkg::PH_TYPE: begin
				if (data_byte == 8'h00) begin
					if (st.depth == '0) begin
						ev        = bst_pkg::EV_DOC_END;
						nxt.phase = bst_pkg::PH_DOCLEN;
					end else begin
						ev        = bst_pkg::EV_SUB_END;
						nxt.depth = st.depth - 1'b1;
					end
					nxt.cnt = '0;
				end else if (!tmap.known) begin
					nxt.err   = bst_pkg::ERR_BAD_TYPE;
					nxt.phase = bst_pkg::PH_ERROR;
				end else begin
					ev            = bst_pkg::EV_TYPE;
					nxt.elem_type = tmap.code;
					nxt.cnt       = '0;
					nxt.phase     = bst_pkg::PH_NAME;
				end
			end
			bst_pkg::PH_NAME: begin
				if (st.cnt >= bst_pkg::CNT_W'(bst_pkg::MAX_NAME_LEN)) begin
					nxt.err   = bst_pkg::ERR_NAME_LONG;
					nxt.phase = bst_pkg::PH_ERROR;
				end else if (data_byte != 8'h00) begin
					ev      = bst_pkg::EV_NAME;
					nxt.cnt = st.cnt + 1'b1;
				end else begin
					nxt.cnt = '0;
					nxt.acc = '0;
					if (st.elem_type == bst_pkg::T_DOC || st.elem_type == bst_pkg::T_ARRAY) begin
						if (st.depth >= bst_pkg::DEPTH_W'(bst_pkg::MAX_DEPTH)) begin
							nxt.err   = bst_pkg::ERR_TOO_DEEP;
							nxt.phase = bst_pkg::PH_ERROR;
						end else begin
							ev        = bst_pkg::EV_NAME_END;
							nxt.depth = st.depth + 1'b1;
							nxt.phase = bst_pkg::PH_DOCLEN;
						end
					end else begin
						ev = bst_pkg::EV_NAME_END;
						if (st.elem_type == bst_pkg::T_NULL) begin
							nxt.phase = bst_pkg::PH_TYPE;
						end else if (st.elem_type == bst_pkg::T_STRING) begin
							nxt.phase = bst_pkg::PH_STRLEN;
						end else begin
							nxt.phase = bst_pkg::PH_VALUE;
						end
					end
				end
			end
			bst_pkg::PH_VALUE: begin
				ev = bst_pkg::EV_VALUE;
				if (st.cnt >= bst_pkg::CNT_W'(bst_pkg::last_value_idx(st.elem_type))) begin
					val = acc_merged;
					if (st.elem_type == bst_pkg::T_INT32 && acc_merged[31]) begin
						val[63:32] = '1;
					end
					vvalid    = 1'b1;
					nxt.cnt   = '0;
					nxt.acc   = '0;
					nxt.phase = bst_pkg::PH_TYPE;
				end else begin
					nxt.acc = acc_merged;
					nxt.cnt = st.cnt + 1'b1;
				end
			end
			bst_pkg::PH_STRLEN: begin
				ev = bst_pkg::EV_STRLEN;
				if (st.cnt >= bst_pkg::CNT_W'(3)) begin
					nxt.acc = '0;
					// A zero or negative length means an empty string.
					if (acc_merged[31:0] == 32'd0 || acc_merged[31]) begin
						nxt.cnt   = '0;
						nxt.phase = bst_pkg::PH_TYPE;
					end else begin
						nxt.cnt   = acc_merged[bst_pkg::CNT_W-1:0];
						nxt.phase = bst_pkg::PH_STRING;
					end
				end else begin
					nxt.acc = acc_merged;
					nxt.cnt = st.cnt + 1'b1;
				end
			end
			bst_pkg::PH_STRING: begin
				ev      = bst_pkg::EV_STRBYTE;
				nxt.cnt = cnt_dec;
				if (cnt_dec == '0) begin
					nxt.phase = bst_pkg::PH_TYPE;
				end
			end
			default: begin
				ev        = bst_pkg::EV_ERROR;
				nxt.phase = bst_pkg::PH_ERROR;
			end
		endcase
	end

	// Result word reflects the state after this byte.
	always_comb begin
		result.ev          = ev;
		result.elem_type   = nxt.elem_type;
		result.byte_value  = data_byte;
		result.value       = val;
		result.value_valid = vvalid;
		result.depth       = nxt.depth;
		result.err         = nxt.err;
	end

	assign nxt_state = nxt;

endmodule

// File: rtl/bson_stream_tokenizer.sv
// Top level of the BSON stream tokenizer: parser state and output register.
//
// Takes one BSON byte per word and returns one tagged result word for it. A byte
// is processed by the next-state logic that closes a loop around the parser state
// register, and the result goes to an output register, so a new byte is accepted
// in every cycle while the consumer keeps up, and also while a finished result
// waits, as long as that result is taken in the same cycle. The result word of an
// accepted byte is registered and appears in the cycle after it is accepted.
// Restart clears the error, the depth and the counters and takes the same byte
// as the first byte of a new document length.
module bson_stream_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  event_res,
	output logic [2:0]  type_code,
	output logic [7:0]  byte_value,
	output logic [63:0] value,
	output logic        value_valid,
	output logic [4:0]  depth,
	output logic [1:0]  error_code
);

	bst_pkg::state_t  state_q;
	bst_pkg::state_t  state_nxt;
	bst_pkg::result_t res;
	bst_pkg::result_t res_s1;
	logic             out_valid_s1;
	logic             accept;

	// A word is taken unless a finished result is held back by the consumer.
	assign in_stall = out_valid_s1 & out_stall;
	assign accept   = in_valid & ~in_stall;

	bst_step u_step (
		.cur_state (state_q),
		.data_byte (data_byte),
		.restart   (restart),
		.nxt_state (state_nxt),
		.result    (res)
	);

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= bst_pkg::PH_DOCLEN;
			state_q.elem_type <= bst_pkg::T_DOUBLE;
			state_q.cnt       <= '0;
			state_q.acc       <= '0;
			state_q.depth     <= '0;
			state_q.err       <= bst_pkg::ERR_NONE;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (accept) begin
			out_valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s1 <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign out_valid   = out_valid_s1;
	assign event_res   = res_s1.ev;
	assign type_code   = res_s1.elem_type;
	assign byte_value  = res_s1.byte_value;
	assign value       = res_s1.value;
	assign value_valid = res_s1.value_valid;
	assign depth       = res_s1.depth;
	assign error_code  = res_s1.err;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the BSON stream tokenizer: directed tests, then random streams.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bst_pkg::*;

	localparam int RANDOM_WORDS = 775;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SHOWN_ERRORS = 10;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte   = 8'h00;
	logic        restart     = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [3:0]  event_res;
	logic [2:0]  type_code;
	logic [7:0]  byte_value;
	logic [63:0] value;
	logic        value_valid;
	logic [4:0]  depth;
	logic [1:0]  error_code;

	bson_stream_tokenizer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_res   (event_res),
		.type_code   (type_code),
		.byte_value  (byte_value),
		.value       (value),
		.value_valid (value_valid),
		.depth       (depth),
		.error_code  (error_code)
	);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Tokenizer state as the testbench tracks it.
	phase_t      parse_phase = PH_DOCLEN;
	elem_type_t  cur_type    = T_DOUBLE;
	logic [31:0] byte_cnt    = '0;
	logic [63:0] asm_bits    = '0;
	logic [4:0]  nest_lvl    = '0;
	err_t        err_held    = ERR_NONE;

	// Tokens predicted for accepted words and not yet seen at the output.
	result_t predicted_tokens[$];

	int words_sent     = 0;
	int burst_left     = 0;
	int mismatch_count = 0;
	int stall_cycle    = 0;
	int stall_mode     = 0;

	// Advances the tracked state by one stream byte and returns the token it yields.
	function automatic result_t tokenize_byte(input logic [7:0] b, input logic rst);
		result_t     r;
		elem_type_t  t;
		logic        known;
		logic [31:0] span;
		r.ev          = EV_ERROR;
		r.value       = '0;
		r.value_valid = 1'b0;
		if (rst) begin
			parse_phase = PH_DOCLEN;
			byte_cnt    = '0;
			asm_bits    = '0;
			nest_lvl    = '0;
			err_held    = ERR_NONE;
		end
		case (parse_phase)
			PH_DOCLEN: begin
				// The four length bytes are only counted.
				r.ev     = EV_DOCLEN;
				byte_cnt = byte_cnt + 1;
				if (byte_cnt >= 4) begin
					byte_cnt    = '0;
					parse_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (b == 8'h00) begin
					// A zero type byte closes the current document.
					if (nest_lvl == 0) begin
						r.ev        = EV_DOC_END;
						parse_phase = PH_DOCLEN;
					end else begin
						r.ev     = EV_SUB_END;
						nest_lvl = nest_lvl - 1'b1;
					end
					byte_cnt = '0;
				end else begin
					known = 1'b1;
					t     = T_DOUBLE;
					case (b)
						BT_DOUBLE:                           t = T_DOUBLE;
						BT_STRING:                           t = T_STRING;
						BT_DOC:                              t = T_DOC;
						BT_ARRAY:                            t = T_ARRAY;
						BT_BOOL:                             t = T_BOOL;
						BT_DATETIME, BT_TIMESTAMP, BT_INT64: t = T_INT64;
						BT_NULL:                             t = T_NULL;
						BT_INT32:                            t = T_INT32;
						default:                             known = 1'b0;
					endcase
					if (!known) begin
						err_held    = ERR_BAD_TYPE;
						parse_phase = PH_ERROR;
					end else begin
						r.ev        = EV_TYPE;
						cur_type    = t;
						byte_cnt    = '0;
						parse_phase = PH_NAME;
					end
				end
			end
			PH_NAME: begin
				if (byte_cnt >= MAX_NAME_LEN) begin
					// Any byte past the longest allowed name fails, the terminator too.
					err_held    = ERR_NAME_LONG;
					parse_phase = PH_ERROR;
				end else if (b != 8'h00) begin
					r.ev     = EV_NAME;
					byte_cnt = byte_cnt + 1;
				end else begin
					byte_cnt = '0;
					asm_bits = '0;
					if (cur_type == T_DOC || cur_type == T_ARRAY) begin
						if (nest_lvl >= MAX_DEPTH) begin
							err_held    = ERR_TOO_DEEP;
							parse_phase = PH_ERROR;
						end else begin
							r.ev        = EV_NAME_END;
							nest_lvl    = nest_lvl + 1'b1;
							parse_phase = PH_DOCLEN;
						end
					end else begin
						r.ev = EV_NAME_END;
						case (cur_type)
							T_NULL:   parse_phase = PH_TYPE;
							T_STRING: parse_phase = PH_STRLEN;
							default:  parse_phase = PH_VALUE;
						endcase
					end
				end
			end
			PH_VALUE: begin
				// Little-endian assembly; the last byte reports the scalar.
				r.ev     = EV_VALUE;
				asm_bits = asm_bits | ({56'd0, b} << (8 * byte_cnt[2:0]));
				byte_cnt = byte_cnt + 1;
				span     = (cur_type == T_BOOL) ? 32'd1 :
					(cur_type == T_INT32) ? 32'd4 : 32'd8;
				if (byte_cnt >= span) begin
					r.value = asm_bits;
					if (cur_type == T_INT32 && asm_bits[31])
						r.value[63:32] = '1;
					r.value_valid = 1'b1;
					byte_cnt      = '0;
					asm_bits      = '0;
					parse_phase   = PH_TYPE;
				end
			end
			PH_STRLEN: begin
				r.ev     = EV_STRLEN;
				asm_bits = asm_bits | ({56'd0, b} << (8 * byte_cnt[1:0]));
				byte_cnt = byte_cnt + 1;
				if (byte_cnt >= 4) begin
					span     = asm_bits[31:0];
					asm_bits = '0;
					// Zero or negative lengths mean an empty string.
					if (span == 0 || span[31]) begin
						byte_cnt    = '0;
						parse_phase = PH_TYPE;
					end else begin
						byte_cnt    = span;
						parse_phase = PH_STRING;
					end
				end
			end
			PH_STRING: begin
				r.ev = EV_STRBYTE;
				if (byte_cnt != 0)
					byte_cnt = byte_cnt - 1;
				if (byte_cnt == 0)
					parse_phase = PH_TYPE;
			end
			default: begin
				// Sticky error until restart.
				parse_phase = PH_ERROR;
				r.ev        = EV_ERROR;
			end
		endcase
		r.elem_type  = cur_type;
		r.byte_value = b;
		r.depth      = nest_lvl;
		r.err        = err_held;
		return r;
	endfunction

	// Sends one word in bursts with random gaps and records its predicted token.
	task automatic feed_byte(input logic [7:0] b, input logic rst);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 40);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		restart   <= rst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted_tokens.push_back(tokenize_byte(b, rst));
		burst_left = burst_left - 1;
		words_sent = words_sent + 1;
	endtask

	// Sends the low n bytes of v, least significant first.
	task automatic feed_le(input logic [63:0] v, input int n);
		int i;
		for (i = 0; i < n; i++)
			feed_byte(v[8*i +: 8], 1'b0);
	endtask

	task automatic feed_doc_length(input logic rst);
		feed_byte(8'($urandom_range(0, 255)), rst);
		repeat (3) feed_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// Type byte followed by a name of len nonzero bytes and its terminator.
	task automatic feed_head(input logic [7:0] code, input int len);
		feed_byte(code, 1'b0);
		repeat (len) feed_byte(8'($urandom_range(1, 255)), 1'b0);
		feed_byte(8'h00, 1'b0);
	endtask

	// String length field and then count string bytes, the last of them zero.
	task automatic feed_string(input logic [31:0] len, input int count);
		int i;
		feed_le({32'd0, len}, 4);
		for (i = 0; i < count; i++)
			feed_byte((i + 1 == count) ? 8'h00 : 8'($urandom_range(1, 255)), 1'b0);
	endtask

	// Opens a document or array element and sends its length field.
	task automatic feed_open(input logic [7:0] code);
		feed_head(code, $urandom_range(0, 2));
		feed_doc_length(1'b0);
	endtask

	task automatic feed_nest(input int levels);
		repeat (levels) feed_open(($urandom_range(0, 1) != 0) ? BT_DOC : BT_ARRAY);
	endtask

	function automatic logic [7:0] random_scalar_code();
		case ($urandom_range(0, 7))
			0:       return BT_DOUBLE;
			1:       return BT_STRING;
			2:       return BT_BOOL;
			3:       return BT_DATETIME;
			4:       return BT_NULL;
			5:       return BT_INT32;
			6:       return BT_TIMESTAMP;
			default: return BT_INT64;
		endcase
	endfunction

	// Any nonzero type byte outside the supported set.
	function automatic logic [7:0] pick_bad_type();
		logic [7:0] b;
		logic       hit;
		b   = 8'h00;
		hit = 1'b1;
		while (hit) begin
			b = 8'($urandom_range(1, 255));
			case (b)
				BT_DOUBLE, BT_STRING, BT_DOC, BT_ARRAY, BT_BOOL, BT_DATETIME,
				BT_NULL, BT_INT32, BT_TIMESTAMP, BT_INT64: hit = 1'b1;
				default:                                   hit = 1'b0;
			endcase
		end
		return b;
	endfunction

	// Scalar bits: mostly random, sometimes all zeros or all ones.
	function automatic logic [63:0] random_scalar();
		case ($urandom_range(0, 5))
			0:       return 64'd0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// One complete scalar or string element with a short random name.
	task automatic feed_scalar(input logic [7:0] code);
		logic [31:0] len;
		feed_head(code, $urandom_range(0, 4));
		case (code)
			BT_STRING: begin
				case ($urandom_range(0, 9))
					0:       len = 32'd0;
					1:       len = 32'h8000_0000 | $urandom;
					default: len = $urandom_range(1, 8);
				endcase
				feed_string(len, len[31] ? 0 : int'(len));
			end
			BT_BOOL: feed_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 1)), 1'b0);
			BT_INT32: feed_le(random_scalar(), 4);
			BT_NULL: ;
			default: feed_le(random_scalar(), 8);
		endcase
	endtask

	// A random document, sometimes cut short or spoiled partway through.
	task automatic feed_random_document(input bit rst_first, output bit broken);
		int lvl;
		int n;
		int i;
		int pick;
		broken = 1'b0;
		lvl    = 0;
		feed_doc_length(rst_first || $urandom_range(0, 3) == 0);
		n = $urandom_range(1, 10);
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				// Element abandoned in the middle of its payload.
				feed_head(random_scalar_code(), $urandom_range(0, 3));
				repeat ($urandom_range(0, 3)) feed_byte(8'($urandom_range(0, 255)), 1'b0);
				broken = 1'b1;
				return;
			end else if (pick < 5) begin
				// String announcing far more bytes than ever follow.
				feed_head(BT_STRING, 1);
				feed_string(($urandom & 32'h7FFF_FFFF) | 32'h0001_0000, $urandom_range(0, 4));
				broken = 1'b1;
				return;
			end else if (pick < 7) begin
				feed_byte(pick_bad_type(), 1'b0);
				feed_byte(8'($urandom_range(0, 255)), 1'b0);
				broken = 1'b1;
				return;
			end else if (pick < 20 && lvl < 5) begin
				feed_nest(1);
				lvl++;
			end else if (pick < 30 && lvl > 0) begin
				feed_byte(8'h00, 1'b0);
				lvl--;
			end else begin
				feed_scalar(random_scalar_code());
			end
		end
		repeat (lvl) feed_byte(8'h00, 1'b0);
		feed_byte(8'h00, 1'b0);
	endtask

	// Every scalar type, value extremes and int32 sign extension.
	task automatic test_scalar_types();
		feed_doc_length(1'b0);
		feed_byte(BT_DOUBLE, 1'b0);
		feed_byte(8'hFF, 1'b0);
		feed_byte(8'h01, 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_le('1, 8);
		feed_head(BT_INT64, 0);
		feed_le(64'd0, 8);
		feed_head(BT_DATETIME, 0);
		feed_le(64'h8877_6655_4433_2211, 8);
		feed_head(BT_TIMESTAMP, 0);
		feed_le(64'h8000_0000_0000_0001, 8);
		feed_head(BT_INT32, 0);
		feed_le(64'h8000_0000, 4);
		feed_head(BT_INT32, 0);
		feed_le(64'h7FFF_FFFF, 4);
		feed_head(BT_BOOL, 0);
		feed_byte(8'h01, 1'b0);
		feed_head(BT_BOOL, 0);
		feed_byte(8'hFF, 1'b0);
		feed_head(BT_NULL, 0);
		feed_byte(8'h00, 1'b0);
	endtask

	// Ordinary, empty and negative string lengths, then a huge one cut by restart.
	task automatic test_strings();
		feed_doc_length(1'b0);
		feed_head(BT_STRING, 1);
		feed_string(32'd3, 3);
		feed_head(BT_STRING, 0);
		feed_string(32'd0, 0);
		feed_head(BT_STRING, 0);
		feed_string(32'hFFFF_FFFF, 0);
		feed_head(BT_STRING, 0);
		feed_string(32'h8000_0000, 0);
		feed_head(BT_STRING, 0);
		feed_string(32'd1, 1);
		feed_head(BT_STRING, 0);
		feed_string(32'h7FFF_FFFF, 3);
	endtask

	// Nested document and array, an empty subdocument and an empty top document.
	task automatic test_subdocuments();
		feed_doc_length(1'b1);
		feed_open(BT_DOC);
		feed_open(BT_ARRAY);
		feed_head(BT_INT32, 1);
		feed_le(64'hFFFF_FFFE, 4);
		feed_byte(8'h00, 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_open(BT_DOC);
		feed_byte(8'h00, 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_doc_length(1'b0);
		feed_byte(8'h00, 1'b0);
	endtask

	// Unknown type, overlong name and nesting limit, each sticky until restart.
	task automatic test_error_paths();
		feed_doc_length(1'b0);
		feed_byte(pick_bad_type(), 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_byte(BT_INT32, 1'b0);
		feed_byte(8'hFF, 1'b0);

		// A name of MAX_NAME_LEN bytes, whose terminator already counts as too long.
		feed_doc_length(1'b1);
		feed_byte(BT_INT32, 1'b0);
		repeat (MAX_NAME_LEN) feed_byte(8'($urandom_range(1, 255)), 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_byte(8'h00, 1'b0);

		// Full depth is legal and unwinds cleanly.
		feed_doc_length(1'b1);
		feed_nest(MAX_DEPTH);
		feed_head(BT_BOOL, 0);
		feed_byte(8'h01, 1'b0);
		repeat (MAX_DEPTH) feed_byte(8'h00, 1'b0);
		feed_byte(8'h00, 1'b0);

		// One level more fails on the name terminator.
		feed_doc_length(1'b0);
		feed_nest(MAX_DEPTH);
		feed_head(BT_ARRAY, 0);
		feed_byte(8'h00, 1'b0);
	endtask

	// Mostly well-formed documents with random content, plus deep, noisy and bad ones.
	task automatic test_random_streams();
		int  first_word;
		int  pick;
		int  lv;
		bit  dirty;
		first_word = words_sent;
		dirty      = 1'b1;
		while (words_sent - first_word < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				feed_random_document(dirty, dirty);
			end else if (pick < 85) begin
				feed_doc_length(dirty);
				lv = $urandom_range(MAX_DEPTH - 2, MAX_DEPTH);
				feed_nest(lv);
				if ($urandom_range(0, 1) != 0) begin
					feed_scalar(random_scalar_code());
					repeat (lv) feed_byte(8'h00, 1'b0);
					feed_byte(8'h00, 1'b0);
					dirty = 1'b0;
				end else begin
					feed_head(($urandom_range(0, 1) != 0) ? BT_DOC : BT_ARRAY, 0);
					dirty = 1'b1;
				end
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 10))
					feed_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				dirty = 1'b1;
			end else begin
				feed_doc_length(dirty);
				feed_byte(pick_bad_type(), 1'b0);
				repeat ($urandom_range(0, 4)) feed_byte(8'($urandom_range(0, 255)), 1'b0);
				dirty = 1'b1;
			end
		end
	endtask

	// Compare each accepted token with the oldest prediction, then pick the next stall.
	always @(posedge clk) begin : check_tokens
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_tokens.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_ERRORS)
					$display("token with no word pending: ev=%0d type=%0d byte=%02h",
						event_res, type_code, byte_value);
			end else begin
				want = predicted_tokens.pop_front();
				if (event_res !== want.ev || type_code !== want.elem_type ||
						byte_value !== want.byte_value || value !== want.value ||
						value_valid !== want.value_valid || depth !== want.depth ||
						error_code !== want.err) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_ERRORS) begin
						$display("expected ev=%0d ty=%0d b=%02h v=%016h vv=%0b d=%0d e=%0d",
							want.ev, want.elem_type, want.byte_value, want.value,
							want.value_valid, want.depth, want.err);
						$display("  actual ev=%0d ty=%0d b=%02h v=%016h vv=%0b d=%0d e=%0d",
							event_res, type_code, byte_value, value, value_valid, depth,
							error_code);
					end
				end
			end
		end

		// Stall pattern switches between four random modes as the run goes on.
		stall_cycle++;
		if (stall_cycle % 256 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 3) == 0);
			2:       out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_cycle % 5 < 2);
		endcase
	end

	// Ends the run when neither channel has moved a word for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("bson_stream_tokenizer regression: fail");
		$finish;
	end

	// Test sequence.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_scalar_types();
		test_strings();
		test_subdocuments();
		test_error_paths();
		test_random_streams();

		in_valid <= 1'b0;
		while (predicted_tokens.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("bson_stream_tokenizer regression: pass");
		else
			$display("bson_stream_tokenizer regression: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/bst_pkg.sv
rtl/bst_step.sv
rtl/bson_stream_tokenizer.sv
dv/tb_top.sv
